@@ src/pfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants of the Playfair digraph cipher: word layouts,
// register indexes, key-square geometry and the control state encoding.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int MAX_KEY_LETTERS_DEF = 48;
   localparam int LETTER_W            = 5;
   localparam int CELLS               = 25;
   localparam int SIDE                = 5;
   localparam int LETTERS_PER_REG     = 12;
   localparam int CSR_DATA_W          = 60;
   localparam int CSR_INDEX_W         = 3;
   localparam int KEY_LEN_W           = 6;

   localparam logic [LETTER_W-1:0] LETTER_X = 5'd22;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_THIRD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_FOURTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION  = 3'd5;

   typedef logic [LETTER_W-1:0] letter_type;

   typedef struct packed {
      letter_type first_letter;
      letter_type second_letter;
      logic       second_present;
   } pfc_req_type;

   typedef struct packed {
      letter_type first_out;
      letter_type second_out;
   } pfc_rsp_type;

   // One square entry written by the builder: square[place] = letter and
   // place_of[letter] = place.
   typedef struct packed {
      logic       we;
      letter_type place;
      letter_type letter;
   } pfc_wr_type;

   typedef struct packed {
      logic place_rd;
      logic square_rd;
   } pfc_lane_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_BUILD  = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_READ   = 4'b1000
   } pfc_state_type;

endpackage

@@ src/pfc_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_lane
// One letter lane: a private copy of the letter-to-place map and of the key
// square, each with one registered read port.
// ----------------------------------------------------------------------------
module pfc_lane (
   input  logic                      clock,
   input  pfc_pkg::pfc_wr_type       wr,
   input  pfc_pkg::pfc_lane_ctl_type ctl,
   input  pfc_pkg::letter_type       letter,
   input  pfc_pkg::letter_type       target,
   output pfc_pkg::letter_type       place_q,
   output pfc_pkg::letter_type       square_q
);
   import pfc_pkg::*;

   letter_type place_mem  [CELLS];
   letter_type square_mem [CELLS];
   letter_type place_ff;
   letter_type square_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         place_mem[wr.letter] <= wr.place;
         square_mem[wr.place] <= wr.letter;
      end
   end

   // Hold read data until the next read is requested.
   always_ff @(posedge clock) begin
      if (ctl.place_rd) begin
         place_ff <= place_mem[letter];
      end
      if (ctl.square_rd) begin
         square_ff <= square_mem[target];
      end
   end

   assign place_q  = place_ff;
   assign square_q = square_ff;

endmodule

@@ src/pfc_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_merge
// Combine the two lane places: pick the row, column or rectangle rule and
// form the square place that each lane reads next.
// ----------------------------------------------------------------------------
module pfc_merge (
   input  logic                direction,
   input  pfc_pkg::letter_type place_a,
   input  pfc_pkg::letter_type place_b,
   output pfc_pkg::letter_type target_a,
   output pfc_pkg::letter_type target_b
);
   import pfc_pkg::*;

   function automatic logic [2:0] row_of(input letter_type p);
      logic [2:0] r;
      if (p < 5'd5) begin
         r = 3'd0;
      end else if (p < 5'd10) begin
         r = 3'd1;
      end else if (p < 5'd15) begin
         r = 3'd2;
      end else if (p < 5'd20) begin
         r = 3'd3;
      end else begin
         r = 3'd4;
      end
      return r;
   endfunction

   function automatic logic [2:0] col_of(input letter_type p, input logic [2:0] r);
      letter_type c;
      c = p - ({r, 2'b00} + {2'b00, r});
      return c[2:0];
   endfunction

   // Advance one place around the row or column, left/up when deciphering.
   function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic back);
      logic [2:0] n;
      if (back) begin
         n = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
      end else begin
         n = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
      end
      return n;
   endfunction

   function automatic letter_type cell_of(input logic [2:0] r, input logic [2:0] c);
      return {r, 2'b00} + {2'b00, r} + {2'b00, c};
   endfunction

   logic [2:0] r1, c1, r2, c2;

   always_comb begin
      r1 = row_of(place_a);
      c1 = col_of(place_a, r1);
      r2 = row_of(place_b);
      c2 = col_of(place_b, r2);
      if (r1 == r2) begin
         target_a = cell_of(r1, wrap_step(c1, direction));
         target_b = cell_of(r2, wrap_step(c2, direction));
      end else if (c1 == c2) begin
         target_a = cell_of(wrap_step(r1, direction), c1);
         target_b = cell_of(wrap_step(r2, direction), c2);
      end else begin
         target_a = cell_of(r1, c2);
         target_b = cell_of(r2, c1);
      end
   end

endmodule

@@ src/pfc_build.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_build
// Key-square sequencer: places one key letter per cycle, skipping repeats
// and codes above 24, then sweeps the alphabet for the unused letters.
// ----------------------------------------------------------------------------
module pfc_build #(
   parameter int MAX_KEY_LETTERS = pfc_pkg::MAX_KEY_LETTERS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  pfc_pkg::letter_type             key_letters [MAX_KEY_LETTERS],
   input  logic [pfc_pkg::KEY_LEN_W-1:0]   key_count,
   output pfc_pkg::pfc_wr_type             wr,
   output logic                            done
);
   import pfc_pkg::*;

   localparam int KEY_IDX_W = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_KEY  = 3'b010,
      PH_FILL = 3'b100
   } phase_type;

   phase_type              phase_ff,   phase_in;
   logic [CELLS-1:0]       used_ff,    used_in;
   letter_type             fill_ff,    fill_in;
   logic [KEY_IDX_W-1:0]   key_idx_ff, key_idx_in;
   letter_type             alpha_ff,   alpha_in;

   letter_type key_code;
   logic       key_new;
   logic       key_last;

   always_comb begin
      key_code = key_letters[key_idx_ff];
      key_new  = (key_code < LETTER_W'(CELLS)) && !used_ff[key_code];
      key_last = (KEY_LEN_W'(key_idx_ff) == KEY_LEN_W'(key_count - 1'b1));

      phase_in   = phase_ff;
      used_in    = used_ff;
      fill_in    = fill_ff;
      key_idx_in = key_idx_ff;
      alpha_in   = alpha_ff;
      wr         = '0;
      done       = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               used_in    = '0;
               fill_in    = '0;
               key_idx_in = '0;
               alpha_in   = '0;
               phase_in   = (key_count == '0) ? PH_FILL : PH_KEY;
            end
         end
         PH_KEY: begin
            if (key_new) begin
               wr.we             = 1'b1;
               wr.place          = fill_ff;
               wr.letter         = key_code;
               used_in[key_code] = 1'b1;
               fill_in           = fill_ff + 1'b1;
            end
            if (key_last) begin
               phase_in = PH_FILL;
            end else begin
               key_idx_in = key_idx_ff + 1'b1;
            end
         end
         PH_FILL: begin
            if (!used_ff[alpha_ff]) begin
               wr.we             = 1'b1;
               wr.place          = fill_ff;
               wr.letter         = alpha_ff;
               used_in[alpha_ff] = 1'b1;
               fill_in           = fill_ff + 1'b1;
            end
            if (alpha_ff == LETTER_W'(CELLS - 1)) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               alpha_in = alpha_ff + 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      used_ff    <= used_in;
      fill_ff    <= fill_in;
      key_idx_ff <= key_idx_in;
      alpha_ff   <= alpha_in;
   end

endmodule

@@ src/playfair_digraph_cipher.sv @@
`timescale 1ns / 1ps
// An accepted req word passes the letter registers, the place read and then the square read to rsp_valid.
// A new req word is taken only when idle or as the current word retires, so one word is in flight at a time.
// The first word after reset or a configuration write first waits for the square
//   build, one letter per cycle.
// Reset: synchronous, active high; clears the control state, the key registers,
//   key_length and direction, and marks the square as not built.
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair cipher over a 5x5 key square, one letter pair per word. Two lanes
// look up the places of the two letters in parallel, a merge stage applies
// the row, column or rectangle rule, and the lanes read the result letters.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher #(
   parameter int MAX_KEY_LETTERS = pfc_pkg::MAX_KEY_LETTERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pfc_pkg::pfc_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pfc_pkg::pfc_rsp_type              rsp_data,
   input  logic                              csr_wr_en,
   input  logic [pfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pfc_pkg::*;

   // Configuration registers; only the key letters that can ever be used
   // are stored.
   letter_type             key_ff [MAX_KEY_LETTERS];
   logic [KEY_LEN_W-1:0]   key_length_ff;
   logic                   direction_ff;
   logic                   square_ready_ff, square_ready_in;

   pfc_state_type          state_ff, state_in;
   letter_type             letter_a_ff, letter_b_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   cfg_hit;
   logic                   out_free;
   logic                   req_fire;
   logic                   load_rsp;
   logic                   build_start;
   logic                   build_done;
   logic [KEY_LEN_W-1:0]   key_count;
   letter_type             norm_a, norm_b;

   pfc_wr_type             build_wr;
   pfc_lane_ctl_type       lane_ctl;
   letter_type             place_a, place_b;
   letter_type             target_a, target_b;
   letter_type             square_a, square_b;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign cfg_hit = csr_wr_en && (csr_index inside {[CSR_KEY_FIRST:CSR_DIRECTION]});

   // Key letter k lives in register k/12, slot k%12.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_KEY_LETTERS; k++) begin
            key_ff[k] <= '0;
         end
         key_length_ff <= '0;
         direction_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         for (int k = 0; k < MAX_KEY_LETTERS; k++) begin
            if (csr_index == CSR_INDEX_W'(k / LETTERS_PER_REG)) begin
               key_ff[k] <= csr_data[(k % LETTERS_PER_REG) * LETTER_W +: LETTER_W];
            end
         end
         case (csr_index)
            CSR_KEY_LENGTH: key_length_ff <= csr_data[KEY_LEN_W-1:0];
            CSR_DIRECTION:  direction_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the key length to the stored key letters.
   assign key_count = (key_length_ff > KEY_LEN_W'(MAX_KEY_LETTERS)) ?
                      KEY_LEN_W'(MAX_KEY_LETTERS) : key_length_ff;

   // ------------------------------------------------------------------
   // Handshake and sequencing
   // ------------------------------------------------------------------
   // The output register frees up when it is empty or being taken now.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_rsp  = (state_ff == ST_READ) && out_free;
   // Take a new word when idle, or in the cycle the current one retires.
   assign req_ready = (state_ff == ST_IDLE) || load_rsp;
   assign req_fire  = req_valid && req_ready;
   // Rebuild the square on the first word after reset or a configuration write.
   assign build_start = req_fire && !square_ready_ff;

   // Drop out-of-range codes and a missing second letter to X.
   always_comb begin
      norm_a = (req_data.first_letter < LETTER_W'(CELLS)) ? req_data.first_letter : LETTER_X;
      if (!req_data.second_present || req_data.second_letter >= LETTER_W'(CELLS)) begin
         norm_b = LETTER_X;
      end else begin
         norm_b = req_data.second_letter;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = square_ready_ff ? ST_LOOKUP : ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (build_done) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            // Hold while the result word is still waiting to be taken.
            if (load_rsp) begin
               if (req_fire) begin
                  state_in = square_ready_ff ? ST_LOOKUP : ST_BUILD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      square_ready_in = square_ready_ff;
      if (cfg_hit) begin
         square_ready_in = 1'b0;
      end else if (build_done) begin
         square_ready_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         square_ready_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         square_ready_ff <= square_ready_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Hold the accepted letters for the place lookup.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         letter_a_ff <= norm_a;
         letter_b_ff <= norm_b;
      end
   end

   // ------------------------------------------------------------------
   // Square builder, lanes and merge stage
   // ------------------------------------------------------------------
   pfc_build #(
      .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
   ) u_build (
      .clock       (clock),
      .reset       (reset),
      .start       (build_start),
      .key_letters (key_ff),
      .key_count   (key_count),
      .wr          (build_wr),
      .done        (build_done)
   );

   // Place reads in the lookup cycle; square reads land in the result
   // register as the word retires.
   always_comb begin
      lane_ctl.place_rd  = (state_ff == ST_LOOKUP);
      lane_ctl.square_rd = load_rsp;
   end

   pfc_lane u_lane_a (
      .clock    (clock),
      .wr       (build_wr),
      .ctl      (lane_ctl),
      .letter   (letter_a_ff),
      .target   (target_a),
      .place_q  (place_a),
      .square_q (square_a)
   );

   pfc_lane u_lane_b (
      .clock    (clock),
      .wr       (build_wr),
      .ctl      (lane_ctl),
      .letter   (letter_b_ff),
      .target   (target_b),
      .place_q  (place_b),
      .square_q (square_b)
   );

   pfc_merge u_merge (
      .direction (direction_ff),
      .place_a   (place_a),
      .place_b   (place_b),
      .target_a  (target_a),
      .target_b  (target_b)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.first_out  = square_a;
   assign rsp_data.second_out = square_b;

endmodule

@@ src/pfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks of the cipher: handshake holding, reset, result range
// and the retire spacing of the result register.
// ----------------------------------------------------------------------------
module pfc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input pfc_pkg::pfc_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input pfc_pkg::pfc_rsp_type rsp_data
);
   import pfc_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed or dropped while stalled");

   // A stalled request word holds.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req word changed or dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid not cleared by reset");

   // Results always come from a built square.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.first_out < 5'd25) && (rsp_data.second_out < 5'd25))
      else $error("result letter code out of range");

   // Words cannot retire back to back without a gap: two takes in a row empty the
   // result register.
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) ##1 (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("result register refilled faster than one word per two cycles");

endmodule

bind playfair_digraph_cipher pfc_checker u_checker (.*);
